FILE: rtl/core/tdp_pkg.sv
// shared types for the trial division prime test
// no dependencies
package tdp_pkg;

    typedef struct packed {
        logic done;
        logic rem_zero;
    } t_div_flags;

endpackage

FILE: rtl/core/tdp_div.sv
// bit-serial restoring divider, one quotient bit per cycle
// depends on tdp_pkg
module tdp_div #(
    parameter int WIDTH = 32
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_go,
    input  logic [WIDTH-1:0]    i_dividend,
    input  logic [WIDTH-1:0]    i_divisor,
    output logic [WIDTH-1:0]    o_quotient,
    output tdp_pkg::t_div_flags o_flags
);
    import tdp_pkg::*;

    localparam int CNT_W = $clog2(WIDTH + 1);

    logic [WIDTH-1:0] r_rem, n_rem;
    logic [WIDTH-1:0] r_quo, n_quo;
    logic [WIDTH-1:0] r_div;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_done, n_done;

    logic [WIDTH:0]   shifted;
    logic [WIDTH:0]   diff;
    logic             ge;

    always_comb begin
        shifted = {r_rem, r_quo[WIDTH-1]};
        ge      = shifted >= {1'b0, r_div};
        diff    = shifted - {1'b0, r_div};
        n_rem   = r_rem;
        n_quo   = r_quo;
        n_cnt   = r_cnt;
        n_done  = 1'b0;
        if (i_go) begin
            n_rem = '0;
            n_quo = i_dividend;
            n_cnt = CNT_W'(WIDTH);
        end else if (r_cnt != '0) begin
            n_rem  = ge ? diff[WIDTH-1:0] : shifted[WIDTH-1:0];
            n_quo  = {r_quo[WIDTH-2:0], ge};
            n_cnt  = r_cnt - CNT_W'(1);
            n_done = (r_cnt == CNT_W'(1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_cnt  <= n_cnt;
            r_done <= n_done;
        end
        r_rem <= n_rem;
        r_quo <= n_quo;
        if (i_go) begin
            r_div <= i_divisor;
        end
    end

    assign o_quotient       = r_quo;
    assign o_flags.done     = r_done;
    assign o_flags.rem_zero = (r_rem == '0);

    a_done_after_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_cnt) == CNT_W'(1))
        else $error("divider done without final step");
    a_go_loads_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_go |=> r_cnt == CNT_W'(WIDTH))
        else $error("divider count not loaded");
    a_rem_below_divisor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> r_rem < r_div)
        else $error("remainder not below divisor");

endmodule

FILE: rtl/core/trial_division_prime_test.sv
// Trial division prime test. A number is taken when start is high and busy is low;
// the answer for 0..3 and even numbers is decided in the evaluate state; for odd numbers
// each odd trial divisor 3, 5, 7, ... up to the square root is tried in turn by the bit-serial divider,
// producing one quotient bit per cycle. The answer appears on o_is_prime for exactly one
// cycle with o_valid and must be taken then; the receiver cannot stall the block.
// depends on tdp_pkg and tdp_div
module trial_division_prime_test #(
    parameter int WIDTH = 32
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    input  logic [WIDTH-1:0] i_number_value,
    output logic             busy,
    output logic             o_valid,
    output logic             o_is_prime
);
    import tdp_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EVAL = 2'd1;
    localparam logic [1:0] S_DIV  = 2'd2;

    localparam logic [WIDTH-1:0] FIRST_DIVISOR = WIDTH'(3);
    localparam logic [WIDTH-1:0] DIVISOR_STEP  = WIDTH'(2);

    logic [1:0]       r_state, n_state;
    logic [WIDTH-1:0] r_n;
    logic [WIDTH-1:0] r_d, n_d;
    logic             r_go, n_go;
    logic             r_valid, n_valid;
    logic             r_prime, n_prime;

    logic [WIDTH-1:0] quotient;
    t_div_flags       flags;

    tdp_div #(
        .WIDTH(WIDTH)
    ) u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_go      (r_go),
        .i_dividend(r_n),
        .i_divisor (r_d),
        .o_quotient(quotient),
        .o_flags   (flags)
    );

    always_comb begin
        n_state = r_state;
        n_d     = r_d;
        n_go    = 1'b0;
        n_valid = 1'b0;
        n_prime = r_prime;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_state = S_EVAL;
                end
            end
            S_EVAL: begin
                if (r_n[WIDTH-1:1] == '0) begin
                    n_valid = 1'b1;
                    n_prime = 1'b0;
                    n_state = S_IDLE;
                end else if (r_n[WIDTH-1:2] == '0) begin
                    n_valid = 1'b1;
                    n_prime = 1'b1;
                    n_state = S_IDLE;
                end else if (!r_n[0]) begin
                    n_valid = 1'b1;
                    n_prime = 1'b0;
                    n_state = S_IDLE;
                end else begin
                    n_d     = FIRST_DIVISOR;
                    n_go    = 1'b1;
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                if (flags.done) begin
                    if (r_d > quotient) begin
                        n_valid = 1'b1;
                        n_prime = 1'b1;
                        n_state = S_IDLE;
                    end else if (flags.rem_zero) begin
                        n_valid = 1'b1;
                        n_prime = 1'b0;
                        n_state = S_IDLE;
                    end else begin
                        n_d  = r_d + DIVISOR_STEP;
                        n_go = 1'b1;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_go    <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_go    <= n_go;
            r_valid <= n_valid;
        end
        r_d     <= n_d;
        r_prime <= n_prime;
        if (start && !busy) begin
            r_n <= i_number_value;
        end
    end

    assign busy       = (r_state != S_IDLE);
    assign o_valid    = r_valid;
    assign o_is_prime = r_prime;

    a_accept_goes_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("accepted word did not raise busy");
    a_valid_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy && $past(busy))
        else $error("result strobe outside end of item");
    a_div_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        flags.done |-> r_state == S_DIV)
        else $error("divider finished outside divide state");
    a_prime_is_odd_or_small: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_is_prime |-> r_n[0] || r_n == WIDTH'(2))
        else $error("even number above two reported prime");

endmodule

FILE: sim/trial_division_prime_test_test.sv
// testbench for trial_division_prime_test: sends numbers, predicts primality per word
// and checks every answer in order; depends only on the block itself
module trial_division_prime_test_test;

    localparam int WIDTH = 32;
    localparam int TRIAL_BUDGET = 600;
    localparam int TAIL_CYCLES = 40;

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             start = 1'b0;
    logic [WIDTH-1:0] i_number_value = '0;
    logic             busy;
    logic             o_valid;
    logic             o_is_prime;

    bit               prime_answers[$];
    logic [WIDTH-1:0] pending_numbers[$];
    int unsigned      bad_words = 0;
    bit               allow_gaps = 1'b1;
    bit               want_prime;
    logic [WIDTH-1:0] want_number;

    trial_division_prime_test #(.WIDTH(WIDTH)) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .i_number_value (i_number_value),
        .busy           (busy),
        .o_valid        (o_valid),
        .o_is_prime     (o_is_prime)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic bit prime_of(input logic [WIDTH-1:0] n, output int unsigned trials);
        longint unsigned v;
        longint unsigned d;
        v = n;
        trials = 0;
        if (v < 2) return 1'b0;
        if (v < 4) return 1'b1;
        if (v % 2 == 0) return 1'b0;
        for (d = 3; d <= v / d; d += 2) begin
            trials++;
            if (v % d == 0) return 1'b0;
        end
        return 1'b1;
    endfunction

    task automatic send_number(input logic [WIDTH-1:0] n);
        int unsigned trials;
        start <= 1'b1;
        i_number_value <= n;
        do @(posedge i_clk); while (busy);
        prime_answers.push_back(prime_of(n, trials));
        pending_numbers.push_back(n);
        if (allow_gaps && $urandom_range(99) < 32) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
    endtask

    task automatic drain;
        start <= 1'b0;
        while (prime_answers.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            if (prime_answers.size() == 0) begin
                bad_words++;
                if (bad_words <= 10)
                    $display("unexpected word: is_prime=%0b", o_is_prime);
            end else begin
                want_prime = prime_answers.pop_front();
                want_number = pending_numbers.pop_front();
                if (o_is_prime !== want_prime) begin
                    bad_words++;
                    if (bad_words <= 10)
                        $display("mismatch for %0d: expected is_prime=%0b, got %0b",
                                 want_number, want_prime, o_is_prime);
                end
            end
        end
    end

    task automatic test_small_numbers;
        send_number(0);
        send_number(1);
        send_number(2);
        send_number(3);
        send_number(4);
        send_number(5);
        send_number(9);
        send_number(25);
        send_number(49);
        drain();
    endtask

    task automatic test_extremes;
        send_number(32'hFFFF_FFFF);
        send_number(32'hFFFF_FFFE);
        send_number(32'h8000_0000);
        send_number(32'h8000_0001);
        send_number(32'hAAAA_AAAA);
        send_number(32'h5555_5555);
        drain();
    endtask

    // perfect squares hit the divisor limit exactly
    task automatic test_squares_and_primes;
        send_number(121);
        send_number(63001);
        send_number(65535);
        send_number(65537);
        send_number(1000003);
        send_number(32'hFFFE_0001);
        drain();
    endtask

    task automatic test_random_numbers;
        logic [WIDTH-1:0] n;
        int unsigned      trials;
        int unsigned      pick;
        for (int i = 0; i < 100; i++) begin
            allow_gaps = !(i >= 40 && i < 70);
            do begin
                pick = $urandom_range(99);
                if (pick < 55)
                    n = $urandom_range(0, 4095);
                else if (pick < 80)
                    n = $urandom_range(0, (1 << 20) - 1);
                else
                    n = $urandom;
                void'(prime_of(n, trials));
            end while (trials > TRIAL_BUDGET);
            send_number(n);
        end
        allow_gaps = 1'b1;
        drain();
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_small_numbers();
        test_extremes();
        test_squares_and_primes();
        test_random_numbers();
        if (bad_words == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    initial begin
        #50_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule

FILE: sim.f
rtl/core/tdp_pkg.sv
rtl/core/tdp_div.sv
rtl/core/trial_division_prime_test.sv
sim/trial_division_prime_test_test.sv
